[rtl/core/mcq_pkg.sv]
// shared types and constants of the multiple circular queue core
`timescale 1ns / 1ps
package mcq_pkg;
   localparam int DATA_W         = 32;
   localparam int FUNC_W         = 2;
   localparam int SEL_W          = 2;
   localparam int STATUS_W       = 2;
   localparam int CAP_W          = 5;
   localparam int NUM_REGS       = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = CAP_W;
   localparam int DEF_NUM_QUEUES = 4;
   localparam int DEF_MAX_DEPTH  = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_LIST = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DEQ_WAIT,
      S_LIST_RD,
      S_LIST_WAIT
   } state_type;
endpackage

[rtl/core/mcq_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface mcq_req_if import mcq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [SEL_W-1:0]         queue_sel;
   logic signed [DATA_W-1:0] data;

   modport source (output valid, output func, output queue_sel, output data, input ready);
   modport sink   (input valid, input func, input queue_sel, input data, output ready);
endinterface

interface mcq_rsp_if import mcq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, output status, output value, output last, input ready);
   modport sink   (input valid, input status, input value, input last, output ready);
endinterface

[rtl/core/multi_circular_queue_core.sv]
// top level of the multiple circular queue core
//
//   channel   direction  handshake      word
//   req_bus   in         valid/ready    func, queue_sel, data
//   rsp_bus   out        valid/ready    status, value, last
//   csr_*     in         write enable   capacity of queue csr_index
//
// enqueue and dequeue each answer with one response; func code 3 gives no response
// listing returns one word per entry: one read of the single-port entry memory per word
// reset is synchronous; every queue starts empty, capacities at 16
// one item is in flight at a time; a held response stalls the sequencer only
// when the next word is ready to be registered
`timescale 1ns / 1ps
module multi_circular_queue_core import mcq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   mcq_req_if.sink               req_bus,
   mcq_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   logic [IDX_W:0]      cap [NUM_QUEUES];
   logic                mem_we;
   logic                mem_re;
   logic [QW-1:0]       mem_q;
   logic [IDX_W-1:0]    mem_idx;
   logic [DATA_W-1:0]   mem_wdata;
   logic [DATA_W-1:0]   mem_rdata;

   mcq_cap_regs #(
      .NUM_QUEUES (NUM_QUEUES),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_cap (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cap       (cap)
   );

   mcq_store #(
      .NUM_QUEUES (NUM_QUEUES),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_store (
      .clock (clock),
      .wr_en (mem_we),
      .rd_en (mem_re),
      .qsel  (mem_q),
      .idx   (mem_idx),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   mcq_ctrl #(
      .NUM_QUEUES (NUM_QUEUES),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .cap       (cap),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_q     (mem_q),
      .mem_idx   (mem_idx),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );
endmodule

[rtl/core/mcq_cap_regs.sv]
// capacity registers and effective capacity per queue
`timescale 1ns / 1ps
module mcq_cap_regs import mcq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1):0] cap [NUM_QUEUES]
);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int NW    = IDX_W + 1;

   logic [CAP_W-1:0] cap_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            cap_ff[r] <= CAP_RESET;
         end
      end else if (csr_we && (int'(csr_index) < NUM_QUEUES)) begin
         cap_ff[csr_index] <= csr_wdata;
      end
   end

   for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_cap
      if (q < NUM_REGS) begin : g_reg
         always_comb begin
            if (cap_ff[q] == '0) begin
               cap[q] = NW'(1);
            end else if (int'(cap_ff[q]) > MAX_DEPTH) begin
               cap[q] = NW'(MAX_DEPTH);
            end else begin
               cap[q] = NW'(cap_ff[q]);
            end
         end
      end else begin : g_fixed
         assign cap[q] = NW'(MAX_DEPTH);
      end
   end
endmodule

[rtl/core/mcq_store.sv]
// shared entry memory, one port, registered read data
`timescale 1ns / 1ps
module mcq_store import mcq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] qsel,
   input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0]   idx,
   input  logic [DATA_W-1:0]     wdata,
   output logic [DATA_W-1:0]     rdata
);
   logic [DATA_W-1:0] mem [NUM_QUEUES][MAX_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[qsel][idx] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[qsel][idx];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/core/mcq_ctrl.sv]
// sequencer, queue pointer table and response register
`timescale 1ns / 1ps
module mcq_ctrl import mcq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic clock,
   input  logic reset,
   mcq_req_if.sink   req_bus,
   mcq_rsp_if.source rsp_bus,
   input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1):0] cap [NUM_QUEUES],
   output logic                  mem_we,
   output logic                  mem_re,
   output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] mem_q,
   output logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0]   mem_idx,
   output logic [DATA_W-1:0]     mem_wdata,
   input  logic [DATA_W-1:0]     mem_rdata
);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int NW    = IDX_W + 1;
   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   function automatic logic [QW-1:0] wrap_sel(input logic [SEL_W-1:0] s);
      logic [SEL_W:0] v;
      v = {1'b0, s};
      for (int k = 0; k < (1 << SEL_W); k++) begin
         if (int'(v) >= NUM_QUEUES) begin
            v = v - (SEL_W+1)'(NUM_QUEUES);
         end
      end
      return QW'(v);
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [NW-1:0] c);
      logic [NW-1:0] n;
      n = NW'(i) + NW'(1);
      return (n >= c) ? '0 : n[IDX_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [DATA_W-1:0] data_ff, data_in;

   logic [IDX_W-1:0]  front_ff [NUM_QUEUES];
   logic [IDX_W-1:0]  rear_ff  [NUM_QUEUES];
   logic              empty_ff [NUM_QUEUES];
   logic              ptr_we;
   logic [IDX_W-1:0]  front_in, rear_in;
   logic              empty_in;

   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              push;
   logic              out_free;
   logic              accept;
   logic [NW-1:0]     cap_q;
   logic [IDX_W-1:0]  front_q, rear_q, rear_nxt;
   logic              empty_q;

   assign cap_q    = cap[q_ff];
   assign front_q  = front_ff[q_ff];
   assign rear_q   = rear_ff[q_ff];
   assign empty_q  = empty_ff[q_ff];
   assign rear_nxt = next_idx(rear_q, cap_q);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept   = req_bus.valid && req_bus.ready;
   assign mem_q    = q_ff;
   assign mem_wdata = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            front_ff[q] <= '0;
            rear_ff[q]  <= '0;
            empty_ff[q] <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ptr_we) begin
            front_ff[q_ff] <= front_in;
            rear_ff[q_ff]  <= rear_in;
            empty_ff[q_ff] <= empty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      q_ff          <= q_in;
      data_ff       <= data_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      done_ff       <= done_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      q_in          = q_ff;
      data_in       = data_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      done_in       = done_ff;
      ptr_we        = 1'b0;
      front_in      = front_q;
      rear_in       = rear_q;
      empty_in      = empty_q;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_idx       = front_q;
      push          = 1'b0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;
      rsp_value_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = func_type'(req_bus.func);
               q_in     = wrap_sel(req_bus.queue_sel);
               data_in  = req_bus.data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (func_ff)
               FUNC_ENQ: begin
                  if (out_free) begin
                     push     = 1'b1;
                     state_in = S_IDLE;
                     if (empty_q) begin
                        mem_we   = 1'b1;
                        mem_idx  = '0;
                        ptr_we   = 1'b1;
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b0;
                     end else if (rear_nxt == front_q) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        mem_idx = rear_nxt;
                        ptr_we  = 1'b1;
                        rear_in = rear_nxt;
                     end
                  end
               end
               FUNC_DEQ: begin
                  if (empty_q) begin
                     if (out_free) begin
                        push          = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     mem_re  = 1'b1;
                     mem_idx = front_q;
                     ptr_we  = 1'b1;
                     if (front_q == rear_q) begin
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b1;
                     end else begin
                        front_in = next_idx(front_q, cap_q);
                     end
                     state_in = S_DEQ_WAIT;
                  end
               end
               FUNC_LIST: begin
                  if (empty_q) begin
                     if (out_free) begin
                        push          = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     cur_in   = front_q;
                     cnt_in   = '0;
                     state_in = S_LIST_RD;
                  end
               end
               FUNC_NOP: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DEQ_WAIT: begin
            if (out_free) begin
               push         = 1'b1;
               rsp_value_in = mem_rdata;
               state_in     = S_IDLE;
            end
         end
         S_LIST_RD: begin
            mem_re   = 1'b1;
            mem_idx  = cur_ff;
            done_in  = (cur_ff == rear_q) || (int'(cnt_ff) == MAX_DEPTH - 1);
            state_in = S_LIST_WAIT;
         end
         S_LIST_WAIT: begin
            if (out_free) begin
               push         = 1'b1;
               rsp_value_in = mem_rdata;
               rsp_last_in  = done_ff;
               if (done_ff) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = next_idx(cur_ff, cap_q);
                  cnt_in   = cnt_ff + IDX_W'(1);
                  state_in = S_LIST_RD;
               end
            end
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (!push) begin
         rsp_status_in = rsp_status_ff;
         rsp_value_in  = rsp_value_ff;
         rsp_last_in   = rsp_last_ff;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.last   = rsp_last_ff;
endmodule
